// File: rtl/ready_sleep_thread_scheduler_unit_macros.svh
// assertion macros for the thread scheduler
`ifndef READY_SLEEP_THREAD_SCHEDULER_UNIT_MACROS_SVH
`define READY_SLEEP_THREAD_SCHEDULER_UNIT_MACROS_SVH
`define RSTS_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define RSTS_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// File: rtl/rsts_pkg.sv
// types and codes shared by the thread scheduler
package rsts_pkg;
    localparam logic [2:0] OP_BOOT = 3'd0;
    localparam logic [2:0] OP_ATTACH = 3'd1;
    localparam logic [2:0] OP_YIELD = 3'd2;
    localparam logic [2:0] OP_SLEEP = 3'd3;
    localparam logic [2:0] OP_WAKE = 3'd4;
    localparam logic [2:0] OP_SWITCH = 3'd5;
    localparam logic [1:0] ST_ABSENT = 2'd0;
    localparam logic [1:0] ST_READY = 2'd1;
    localparam logic [1:0] ST_SLEEPING = 2'd2;
    localparam logic [1:0] RES_SWITCHED = 2'd0;
    localparam logic [1:0] RES_STAYED = 2'd1;
    localparam logic [1:0] RES_CANCELLED = 2'd2;
    localparam logic [1:0] RES_ERROR = 2'd3;
    typedef struct packed {
        logic [2:0] op;
        logic [3:0] thread_id;
        logic       attach_asleep;
    } in_item_t;
    typedef struct packed {
        logic [1:0] status;
        logic [3:0] running_id;
        logic       switched;
    } out_item_t;
endpackage

// File: rtl/rsts_front.sv
// input stage and two-entry queue of scheduling events
module rsts_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rsts_pkg::in_item_t in_data,
    output logic               q_valid,
    input  logic               q_ready,
    output rsts_pkg::in_item_t q_data
);
    rsts_pkg::in_item_t mem_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = mem_reg[rd_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wr_reg <= ~wr_reg;
            if (pop) rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// File: rtl/rsts_back.sv
// scheduling state, compacting ready queue and result register
module rsts_back #(
    parameter int MAX_THREADS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_ready,
    input  rsts_pkg::in_item_t  q_data,
    output logic                out_valid,
    input  logic                out_ready,
    output rsts_pkg::out_item_t out_data,
    output logic [$clog2(MAX_THREADS+1)-1:0] count
);
    localparam int CW = $clog2(MAX_THREADS + 1);
    localparam int NT = (MAX_THREADS < 16) ? MAX_THREADS : 16;

    logic [1:0] st_reg [NT];
    logic [1:0] st_next [NT];
    logic [NT-1:0] wp_reg, wp_next;
    logic [3:0] fifo_reg [MAX_THREADS];
    logic [3:0] fifo_next [MAX_THREADS];
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] last_idx;
    logic [3:0] run_reg, run_next;
    logic run_v_reg, run_v_next;
    rsts_pkg::out_item_t res_reg;
    logic [1:0] res;
    logic take, id_ok, found;
    logic [MAX_THREADS-1:0] hit, after;
    logic [1:0] st_id;
    logic wp_run;
    logic [3:0] rem_shift_out;

    assign q_ready   = !out_valid || out_ready;
    assign take      = q_valid && q_ready;
    assign out_data  = res_reg;
    assign count     = cnt_reg;
    assign id_ok     = ({28'd0, q_data.thread_id} < 32'(MAX_THREADS));
    assign st_id     = id_ok ? st_reg[q_data.thread_id[$clog2(NT)-1:0]] : rsts_pkg::ST_ABSENT;
    assign wp_run    = wp_reg[run_reg[$clog2(NT)-1:0]];
    assign rem_shift_out = fifo_reg[0];
    assign last_idx  = cnt_reg - 1'b1;

    always_comb
    begin
        for (int i = 0; i < MAX_THREADS; i++)
        begin
            hit[i] = (CW'(i) < cnt_reg) && (fifo_reg[i] == q_data.thread_id);
        end
        after[0] = hit[0];
        for (int i = 1; i < MAX_THREADS; i++)
        begin
            after[i] = after[i-1] || hit[i];
        end
        found = after[MAX_THREADS-1];
    end

    always_comb
    begin
        st_next = st_reg;
        wp_next = wp_reg;
        fifo_next = fifo_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        run_v_next = run_v_reg;
        res = rsts_pkg::RES_ERROR;
        case (q_data.op)
            rsts_pkg::OP_BOOT:
            begin
                if (!run_v_reg && id_ok && st_id == rsts_pkg::ST_ABSENT)
                begin
                    st_next[q_data.thread_id[$clog2(NT)-1:0]] = rsts_pkg::ST_READY;
                    run_next = q_data.thread_id;
                    run_v_next = 1'b1;
                    res = rsts_pkg::RES_SWITCHED;
                end
            end
            rsts_pkg::OP_ATTACH:
            begin
                if (id_ok && st_id == rsts_pkg::ST_ABSENT)
                begin
                    if (q_data.attach_asleep)
                    begin
                        st_next[q_data.thread_id[$clog2(NT)-1:0]] = rsts_pkg::ST_SLEEPING;
                        res = rsts_pkg::RES_STAYED;
                    end
                    else if (cnt_reg < CW'(MAX_THREADS))
                    begin
                        fifo_next[cnt_reg[$clog2(MAX_THREADS)-1:0]] = q_data.thread_id;
                        cnt_next = cnt_reg + 1'b1;
                        st_next[q_data.thread_id[$clog2(NT)-1:0]] = rsts_pkg::ST_READY;
                        res = rsts_pkg::RES_STAYED;
                    end
                end
            end
            rsts_pkg::OP_YIELD:
            begin
                if (run_v_reg)
                begin
                    if (cnt_reg == '0)
                    begin
                        res = rsts_pkg::RES_STAYED;
                    end
                    else
                    begin
                        for (int i = 0; i < MAX_THREADS - 1; i++)
                        begin
                            fifo_next[i] = fifo_reg[i+1];
                        end
                        fifo_next[last_idx[$clog2(MAX_THREADS)-1:0]] = run_reg;
                        run_next = rem_shift_out;
                        res = rsts_pkg::RES_SWITCHED;
                    end
                end
            end
            rsts_pkg::OP_SLEEP:
            begin
                if (run_v_reg)
                begin
                    if (wp_run)
                    begin
                        wp_next[run_reg[$clog2(NT)-1:0]] = 1'b0;
                        res = rsts_pkg::RES_CANCELLED;
                    end
                    else if (cnt_reg != '0)
                    begin
                        st_next[run_reg[$clog2(NT)-1:0]] = rsts_pkg::ST_SLEEPING;
                        for (int i = 0; i < MAX_THREADS - 1; i++)
                        begin
                            fifo_next[i] = fifo_reg[i+1];
                        end
                        cnt_next = cnt_reg - 1'b1;
                        run_next = rem_shift_out;
                        res = rsts_pkg::RES_SWITCHED;
                    end
                end
            end
            rsts_pkg::OP_WAKE:
            begin
                if (id_ok && st_id != rsts_pkg::ST_ABSENT)
                begin
                    if (st_id == rsts_pkg::ST_SLEEPING)
                    begin
                        if (cnt_reg < CW'(MAX_THREADS))
                        begin
                            fifo_next[cnt_reg[$clog2(MAX_THREADS)-1:0]] = q_data.thread_id;
                            cnt_next = cnt_reg + 1'b1;
                            st_next[q_data.thread_id[$clog2(NT)-1:0]] = rsts_pkg::ST_READY;
                            res = rsts_pkg::RES_STAYED;
                        end
                    end
                    else
                    begin
                        wp_next[q_data.thread_id[$clog2(NT)-1:0]] = 1'b1;
                        res = rsts_pkg::RES_STAYED;
                    end
                end
            end
            rsts_pkg::OP_SWITCH:
            begin
                if (run_v_reg && id_ok)
                begin
                    if (q_data.thread_id == run_reg)
                    begin
                        res = rsts_pkg::RES_STAYED;
                    end
                    else if (found)
                    begin
                        for (int i = 0; i < MAX_THREADS - 1; i++)
                        begin
                            if (after[i])
                            begin
                                fifo_next[i] = fifo_reg[i+1];
                            end
                        end
                        fifo_next[last_idx[$clog2(MAX_THREADS)-1:0]] = run_reg;
                        run_next = q_data.thread_id;
                        res = rsts_pkg::RES_SWITCHED;
                    end
                end
            end
            default:
            begin
                res = rsts_pkg::RES_ERROR;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            fifo_reg <= fifo_next;
            res_reg.status <= res;
            res_reg.running_id <= run_v_next ? run_next : 4'd0;
            res_reg.switched <= (res == rsts_pkg::RES_SWITCHED);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NT; i++)
            begin
                st_reg[i] <= rsts_pkg::ST_ABSENT;
            end
            wp_reg    <= '0;
            cnt_reg   <= '0;
            run_reg   <= 4'd0;
            run_v_reg <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                st_reg    <= st_next;
                wp_reg    <= wp_next;
                cnt_reg   <= cnt_next;
                run_reg   <= run_next;
                run_v_reg <= run_v_next;
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end
endmodule

// File: rtl/ready_sleep_thread_scheduler_unit.sv
// top level of the ready/sleep thread scheduler
// channels: in (valid/ready, struct of op, thread_id, attach_asleep) and
// out (valid/ready, struct of status, running_id, switched).
// every event transfer gives exactly one result transfer, in order.
// an event is held in the front queue register, then the back state update
// writes the result register, from which the result transfers to the receiver.
// throughput: one event per cycle while the receiver takes results, set by
// the combinational update of the compacting ready queue in the back part.
// the two-entry front queue keeps taking events while the back part
// waits on a stalled receiver; when it fills, in_ready drops.
// a stalled result holds its value until the receiver takes it.
// reset: all threads absent, no wake pending, empty queue, nothing running;
// no clearing pass, the block is ready right after reset.
// on boot, attach, wake and switch, ids >= MAX_THREADS give an error result.
`include "ready_sleep_thread_scheduler_unit_macros.svh"
module ready_sleep_thread_scheduler_unit #(
    parameter int MAX_THREADS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rsts_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output rsts_pkg::out_item_t out_data
);
    logic q_valid, q_ready;
    rsts_pkg::in_item_t q_data;
    logic [$clog2(MAX_THREADS+1)-1:0] count;

    rsts_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    rsts_back #(.MAX_THREADS(MAX_THREADS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .count(count)
    );

    `RSTS_ASSERT_IMPL(a_count_max, clk, rst_n, 1'b1,
        count <= ($clog2(MAX_THREADS+1))'(MAX_THREADS))
    `RSTS_ASSERT_IMPL(a_switch_code, clk, rst_n, out_valid,
        out_data.switched == (out_data.status == rsts_pkg::RES_SWITCHED))
    `RSTS_ASSERT_NEXT(a_result_follows, clk, rst_n, q_valid && q_ready, out_valid)
endmodule

// File: verif/ready_sleep_thread_scheduler_unit_tb.sv
// testbench for the ready/sleep thread scheduler with a predictor
`timescale 1ns / 100ps

module ready_sleep_thread_scheduler_unit_tb;
    localparam int NTHREADS = 16;
    localparam int IDLE_LIMIT = 5000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    rsts_pkg::in_item_t  in_data;
    logic                out_valid;
    logic                out_ready;
    rsts_pkg::out_item_t out_data;

    ready_sleep_thread_scheduler_unit #(.MAX_THREADS(NTHREADS)) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    // scheduler state mirror
    logic [1:0]  thr_state [NTHREADS];
    logic        thr_wake [NTHREADS];
    logic [3:0]  run_queue [$];
    logic [3:0]  cur_thread;
    logic        cur_valid;

    rsts_pkg::out_item_t expected_results [$];
    int          mismatches;
    int          idle_cycles;
    bit          timed_out;
    bit          sink_idle_on;
    bit          src_idle_on;
    bit          hold_request;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic bit queue_drop(logic [3:0] id);
        for (int i = 0; i < run_queue.size(); i++)
        begin
            if (run_queue[i] == id)
            begin
                run_queue.delete(i);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic rsts_pkg::out_item_t schedule_event(rsts_pkg::in_item_t ev);
        rsts_pkg::out_item_t r;
        logic [1:0] res;
        logic [3:0] prev;
        res = rsts_pkg::RES_ERROR;
        case (ev.op)
            rsts_pkg::OP_BOOT:
                if (!cur_valid && thr_state[ev.thread_id] == rsts_pkg::ST_ABSENT)
                begin
                    thr_state[ev.thread_id] = rsts_pkg::ST_READY;
                    cur_thread = ev.thread_id;
                    cur_valid = 1'b1;
                    res = rsts_pkg::RES_SWITCHED;
                end
            rsts_pkg::OP_ATTACH:
                if (thr_state[ev.thread_id] == rsts_pkg::ST_ABSENT)
                begin
                    if (ev.attach_asleep)
                    begin
                        thr_state[ev.thread_id] = rsts_pkg::ST_SLEEPING;
                        res = rsts_pkg::RES_STAYED;
                    end
                    else if (run_queue.size() < NTHREADS)
                    begin
                        run_queue.push_back(ev.thread_id);
                        thr_state[ev.thread_id] = rsts_pkg::ST_READY;
                        res = rsts_pkg::RES_STAYED;
                    end
                end
            rsts_pkg::OP_YIELD:
                if (cur_valid)
                begin
                    if (run_queue.size() == 0)
                    begin
                        res = rsts_pkg::RES_STAYED;
                    end
                    else
                    begin
                        prev = cur_thread;
                        cur_thread = run_queue.pop_front();
                        run_queue.push_back(prev);
                        res = rsts_pkg::RES_SWITCHED;
                    end
                end
            rsts_pkg::OP_SLEEP:
                if (cur_valid)
                begin
                    if (thr_wake[cur_thread])
                    begin
                        thr_wake[cur_thread] = 1'b0;
                        res = rsts_pkg::RES_CANCELLED;
                    end
                    else if (run_queue.size() != 0)
                    begin
                        thr_state[cur_thread] = rsts_pkg::ST_SLEEPING;
                        cur_thread = run_queue.pop_front();
                        res = rsts_pkg::RES_SWITCHED;
                    end
                end
            rsts_pkg::OP_WAKE:
                if (thr_state[ev.thread_id] == rsts_pkg::ST_SLEEPING)
                begin
                    if (run_queue.size() < NTHREADS)
                    begin
                        run_queue.push_back(ev.thread_id);
                        thr_state[ev.thread_id] = rsts_pkg::ST_READY;
                        res = rsts_pkg::RES_STAYED;
                    end
                end
                else if (thr_state[ev.thread_id] != rsts_pkg::ST_ABSENT)
                begin
                    thr_wake[ev.thread_id] = 1'b1;
                    res = rsts_pkg::RES_STAYED;
                end
            rsts_pkg::OP_SWITCH:
                if (cur_valid)
                begin
                    if (ev.thread_id == cur_thread)
                    begin
                        res = rsts_pkg::RES_STAYED;
                    end
                    else if (queue_drop(ev.thread_id))
                    begin
                        run_queue.push_back(cur_thread);
                        cur_thread = ev.thread_id;
                        res = rsts_pkg::RES_SWITCHED;
                    end
                end
            default:
                res = rsts_pkg::RES_ERROR;
        endcase
        r.status = res;
        r.running_id = cur_valid ? cur_thread : 4'd0;
        r.switched = (res == rsts_pkg::RES_SWITCHED);
        return r;
    endfunction

    task automatic send_event(logic [2:0] op, logic [3:0] id, logic asleep);
        if (src_idle_on && $urandom_range(0, 5) == 0)
        begin
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data.op = op;
        in_data.thread_id = id;
        in_data.attach_asleep = asleep;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expected_results.push_back(schedule_event(in_data));
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic send_random(int n, int well_formed_pct);
        logic [2:0] op;
        logic [3:0] id;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < well_formed_pct)
            begin
                op = 3'($urandom_range(0, 5));
                id = 4'($urandom_range(0, 5));
                if (op == rsts_pkg::OP_BOOT && cur_valid) op = rsts_pkg::OP_YIELD;
            end
            else
            begin
                op = 3'($urandom_range(0, 7));
                id = 4'($urandom_range(0, 15));
            end
            send_event(op, id, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0 && !timed_out) @(negedge clk);
    endtask

    task automatic test_directed();
        send_event(rsts_pkg::OP_YIELD, 4'd0, 1'b0);
        send_event(rsts_pkg::OP_SLEEP, 4'd0, 1'b0);
        send_event(rsts_pkg::OP_SWITCH, 4'd1, 1'b0);
        send_event(rsts_pkg::OP_WAKE, 4'd3, 1'b0);
        send_event(3'd6, 4'd0, 1'b0);
        send_event(3'd7, 4'd15, 1'b1);
        send_event(rsts_pkg::OP_BOOT, 4'd15, 1'b0);
        send_event(rsts_pkg::OP_BOOT, 4'd0, 1'b0);
        send_event(rsts_pkg::OP_ATTACH, 4'd15, 1'b0);
        send_event(rsts_pkg::OP_SLEEP, 4'd0, 1'b0);
        send_event(rsts_pkg::OP_ATTACH, 4'd0, 1'b0);
        send_event(rsts_pkg::OP_ATTACH, 4'd7, 1'b1);
        send_event(rsts_pkg::OP_WAKE, 4'd0, 1'b0);
        send_event(rsts_pkg::OP_WAKE, 4'd15, 1'b0);
        send_event(rsts_pkg::OP_SLEEP, 4'd0, 1'b0);
        send_event(rsts_pkg::OP_SWITCH, 4'd15, 1'b0);
        send_event(rsts_pkg::OP_SWITCH, 4'd7, 1'b0);
        send_event(rsts_pkg::OP_WAKE, 4'd7, 1'b0);
        send_event(rsts_pkg::OP_SWITCH, 4'd7, 1'b0);
        send_event(rsts_pkg::OP_YIELD, 4'd0, 1'b0);
        send_event(rsts_pkg::OP_SLEEP, 4'd0, 1'b0);
        send_event(rsts_pkg::OP_ATTACH, 4'd0, 1'b1);
        wait_drained();
    endtask

    task automatic test_full_queue();
        for (int t = 0; t < NTHREADS; t++) send_event(rsts_pkg::OP_ATTACH, t[3:0], 1'b0);
        for (int t = 0; t < NTHREADS; t++) send_event(rsts_pkg::OP_WAKE, t[3:0], 1'b0);
        for (int t = 0; t < 20; t++) send_event(rsts_pkg::OP_YIELD, 4'd0, 1'b0);
        for (int t = 0; t < 20; t++) send_event(rsts_pkg::OP_SLEEP, 4'd0, 1'b0);
        for (int t = 0; t < NTHREADS; t++) send_event(rsts_pkg::OP_WAKE, t[3:0], 1'b0);
        send_event(rsts_pkg::OP_SWITCH, 4'd9, 1'b0);
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_request = 1'b1;
        send_random(30, 90);
        hold_request = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_idling();
        src_idle_on = 1'b1;
        sink_idle_on = 1'b1;
        send_random(1300, 85);
        wait_drained();
    endtask

    task automatic test_random_streaming();
        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        send_random(450, 85);
        wait_drained();
    endtask

    // result sink with random stalls and a long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_ready <= 1'b0;
                for (int c = 0; c < 60; c++) @(negedge clk);
                hold_request = 1'b0;
            end
            else if (sink_idle_on && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        rsts_pkg::out_item_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: %p", out_data);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (out_data.status !== exp_r.status
                        || out_data.running_id !== exp_r.running_id
                        || out_data.switched !== exp_r.switched)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p actual %p", exp_r, out_data);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        mismatches = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        sink_idle_on = 1'b1;
        src_idle_on = 1'b1;
        hold_request = 1'b0;
        for (int t = 0; t < NTHREADS; t++)
        begin
            thr_state[t] = rsts_pkg::ST_ABSENT;
            thr_wake[t] = 1'b0;
        end
        cur_thread = '0;
        cur_valid = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_full_queue();
        test_backpressure();
        test_random_idling();
        test_random_streaming();
        repeat (20) @(negedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+rtl
rtl/rsts_pkg.sv
rtl/rsts_front.sv
rtl/rsts_back.sv
rtl/ready_sleep_thread_scheduler_unit.sv
verif/ready_sleep_thread_scheduler_unit_tb.sv
